// ===== rtl/looped_wavetable_player_unit_assert.svh =====
// Assertion macros for the looped wavetable player unit.
// Included by the top level; depends on nothing else.
`ifndef LOOPED_WAVETABLE_PLAYER_UNIT_ASSERT_SVH
`define LOOPED_WAVETABLE_PLAYER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LWP_ASSERT_SAME(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LWP_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/lwp_pkg.sv =====
// Shared types and constants of the looped wavetable player.
// No dependencies; imported by every module of the block.
package lwp_pkg;

   localparam int TABLE_DEPTH = 65536;
   localparam int PEDAL_DEPTH = 65536;
   localparam int TAB_AW      = $clog2(TABLE_DEPTH);
   localparam int PED_AW      = $clog2(PEDAL_DEPTH);
   localparam int PED_LW      = PED_AW + 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Command codes carried in req_tuser.
   localparam logic [2:0] CMD_TICK      = 3'd0;
   localparam logic [2:0] CMD_NOTE      = 3'd1;
   localparam logic [2:0] CMD_PEDAL     = 3'd2;
   localparam logic [2:0] CMD_WR_SAMPLE = 3'd3;
   localparam logic [2:0] CMD_WR_PEDAL  = 3'd4;

   // Configuration register indexes.
   localparam logic [2:0] CSR_PHASE_STEP   = 3'd0;
   localparam logic [2:0] CSR_START_POS    = 3'd1;
   localparam logic [2:0] CSR_LOOP_START   = 3'd2;
   localparam logic [2:0] CSR_LOOP_END     = 3'd3;
   localparam logic [2:0] CSR_PEDAL_LENGTH = 3'd4;

   localparam logic [23:0] PHASE_STEP_RST   = 24'd65536;
   localparam logic [15:0] START_POS_RST    = 16'd1820;
   localparam logic [15:0] LOOP_START_RST   = 16'd53834;
   localparam logic [15:0] LOOP_END_RST     = 16'd54002;
   localparam logic [16:0] PEDAL_LENGTH_RST = 17'd1;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_WR_SAMPLE,
      OP_WR_PEDAL
   } op_type;

   // One operation handed from the front part to the back part.
   typedef struct packed {
      op_type                 op;
      logic [TAB_AW-1:0]      tab_addr;  // read position or write address
      logic [PED_AW-1:0]      ped_addr;  // pedal index or write address
      logic [15:0]            frac;
      logic                   ped_en;
      logic signed [15:0]     data;
   } qentry_type;

endpackage

// ===== rtl/looped_wavetable_player_unit.sv =====
// Looped wavetable player: top level joining front, queue and back parts.
// Depends on lwp_pkg, lwp_front, lwp_queue, lwp_back and the assertion header.
//
// Usage: commands arrive on the req_ stream. req_tuser holds the command
// (tick, start note, start pedal, write sample word, write pedal word) and
// req_tdata holds the table address and the signed table word for writes.
// Only a tick produces a transfer on the rsp_ stream: the linearly
// interpolated sample at the current phase plus the pedal word while the
// pedal plays. Registers must be written through the csr_ port only while
// the block is idle; the block does not enforce this. Throughput is one
// command per cycle while the queue has room; phase and pedal state update
// in the front part in the cycle of acceptance, so ticks may run back to
// back. A tick passes queue pop with table read, multiply, then output add.
// A stalled receiver freezes the back pipeline; the four-entry queue keeps
// taking commands until it fills, and then req_tready drops.
// Reset clears phase, pedal state, queue and pipeline valids and loads the
// register reset values; the tables are undefined until written and need
// no clearing pass.
module looped_wavetable_player_unit (
   input  logic        clock,
   input  logic        reset,
   // Command stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] address, [31:16] data (signed)
   input  logic [2:0]  req_tuser,   // [2:0] cmd
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [16:0] sample_out (signed), rest zero
   // Configuration writes.
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import lwp_pkg::*;

`include "looped_wavetable_player_unit_assert.svh"

   logic               req_accept;
   logic               push;
   qentry_type         push_entry;
   logic               q_valid;
   qentry_type         q_entry;
   logic               q_pop;
   logic signed [16:0] rsp_sample;

   // A transfer on the command stream happens whenever a command is offered and the queue has room.
   assign req_accept = req_tvalid && req_tready;

   lwp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_accept  (req_accept),
      .req_cmd     (req_tuser),
      .req_address (req_tdata[15:0]),
      .req_data    ($signed(req_tdata[31:16])),
      .push        (push),
      .push_entry  (push_entry)
   );

   lwp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .ready      (req_tready),
      .q_valid    (q_valid),
      .q_entry    (q_entry)
   );

   lwp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_sample (rsp_sample)
   );

   // The result field sits in the low bits; the upper seven padding bits are zero.
   assign rsp_tdata = {7'b0, rsp_sample};

   // A full queue is the only reason to refuse commands, and a full queue
   // always has an operation to offer the back part.
   `LWP_ASSERT_SAME(a_notready_has_work, clock, reset, !req_tready, q_valid, "ready low with empty queue")
   // The back part never pops an empty queue.
   `LWP_ASSERT_SAME(a_pop_needs_valid, clock, reset, q_pop, q_valid, "pop from empty queue")
   // While a result waits, the pipeline holds and takes nothing from the queue.
   `LWP_ASSERT_SAME(a_stall_no_pop, clock, reset, rsp_tvalid && !rsp_tready, !q_pop, "pop during stall")

endmodule

// ===== rtl/lwp_front.sv =====
// Front part: configuration registers, phase and pedal state, command decode.
// Depends on lwp_pkg; feeds lwp_queue.
module lwp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wen,
   input  logic [2:0]          csr_index,
   input  logic [23:0]         csr_wdata,
   input  logic                req_accept,
   input  logic [2:0]          req_cmd,
   input  logic [15:0]         req_address,
   input  logic signed [15:0]  req_data,
   output logic                push,
   output lwp_pkg::qentry_type push_entry
);
   import lwp_pkg::*;

   logic [23:0]       phase_step_ff;
   logic [15:0]       start_pos_ff;
   logic [15:0]       loop_start_ff;
   logic [15:0]       loop_end_ff;
   logic [16:0]       pedal_length_ff;

   logic [31:0]       phase_ff, phase_in;
   logic              ped_active_ff, ped_active_in;
   logic [PED_AW-1:0] ped_idx_ff, ped_idx_in;

   logic [31:0]       phase_add;
   logic [31:0]       phase_wrap;
   logic [16:0]       len_clamp;
   logic [PED_LW-1:0] len_eff;
   logic [PED_LW-1:0] idx_inc;
   logic              tab_in_range;
   logic              ped_in_range;

   always_comb begin
      phase_add = phase_ff + {8'h00, phase_step_ff};
      if (phase_add > {loop_end_ff, 16'h0000}) begin
         phase_wrap = {phase_add[31:16] + loop_start_ff - loop_end_ff, phase_add[15:0]};
      end else begin
         phase_wrap = phase_add;
      end

      if (pedal_length_ff == 17'd0) begin
         len_clamp = 17'd1;
      end else if (pedal_length_ff > 17'(PEDAL_DEPTH)) begin
         len_clamp = 17'(PEDAL_DEPTH);
      end else begin
         len_clamp = pedal_length_ff;
      end
      len_eff = len_clamp[PED_LW-1:0];
      idx_inc = {1'b0, ped_idx_ff} + PED_LW'(1);

      tab_in_range = ({1'b0, req_address} < 17'(TABLE_DEPTH));
      ped_in_range = ({1'b0, req_address} < 17'(PEDAL_DEPTH));

      phase_in      = phase_ff;
      ped_active_in = ped_active_ff;
      ped_idx_in    = ped_idx_ff;
      push          = 1'b0;
      push_entry.op       = OP_TICK;
      push_entry.tab_addr = phase_ff[16+TAB_AW-1:16];
      push_entry.ped_addr = ped_idx_ff;
      push_entry.frac     = phase_ff[15:0];
      push_entry.ped_en   = ped_active_ff;
      push_entry.data     = req_data;

      if (req_accept) begin
         case (req_cmd)
            CMD_TICK: begin
               push     = 1'b1;
               phase_in = phase_wrap;
               if (ped_active_ff) begin
                  if (idx_inc >= len_eff) begin
                     ped_active_in = 1'b0;
                     ped_idx_in    = '0;
                  end else begin
                     ped_idx_in = idx_inc[PED_AW-1:0];
                  end
               end
            end
            CMD_NOTE: begin
               phase_in = {start_pos_ff, 16'h0000};
            end
            CMD_PEDAL: begin
               ped_active_in = 1'b1;
               ped_idx_in    = '0;
            end
            CMD_WR_SAMPLE: begin
               push                = tab_in_range;
               push_entry.op       = OP_WR_SAMPLE;
               push_entry.tab_addr = req_address[TAB_AW-1:0];
            end
            CMD_WR_PEDAL: begin
               push                = ped_in_range;
               push_entry.op       = OP_WR_PEDAL;
               push_entry.ped_addr = req_address[PED_AW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         ped_active_ff <= 1'b0;
         ped_idx_ff    <= '0;
      end else begin
         phase_ff      <= phase_in;
         ped_active_ff <= ped_active_in;
         ped_idx_ff    <= ped_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= PHASE_STEP_RST;
         start_pos_ff    <= START_POS_RST;
         loop_start_ff   <= LOOP_START_RST;
         loop_end_ff     <= LOOP_END_RST;
         pedal_length_ff <= PEDAL_LENGTH_RST;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_PHASE_STEP:   phase_step_ff   <= csr_wdata;
            CSR_START_POS:    start_pos_ff    <= csr_wdata[15:0];
            CSR_LOOP_START:   loop_start_ff   <= csr_wdata[15:0];
            CSR_LOOP_END:     loop_end_ff     <= csr_wdata[15:0];
            CSR_PEDAL_LENGTH: pedal_length_ff <= csr_wdata[16:0];
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== rtl/lwp_queue.sv =====
// Short operation queue between the front and back parts.
// Depends on lwp_pkg.
module lwp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lwp_pkg::qentry_type push_entry,
   input  logic                pop,
   output logic                ready,
   output logic                q_valid,
   output lwp_pkg::qentry_type q_entry
);
   import lwp_pkg::*;

   qentry_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign ready   = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && ready;
      do_pop    = pop && q_valid;
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/lwp_back.sv =====
// Back part: sample and pedal memories, interpolation pipeline, output register.
// Depends on lwp_pkg; pops operations from lwp_queue.
module lwp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  lwp_pkg::qentry_type q_entry,
   output logic                q_pop,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic signed [16:0]  rsp_sample
);
   import lwp_pkg::*;

   logic signed [15:0] sample_mem [TABLE_DEPTH];
   logic signed [15:0] pedal_mem  [PEDAL_DEPTH];

   logic               adv;
   logic               pop_tick;
   logic [TAB_AW-1:0]  tab_addr_nxt;

   // Stage 1: table reads.
   logic               s1_valid_ff;
   logic signed [15:0] s1_a_ff, s1_b_ff, s1_p_ff;
   logic [15:0]        s1_frac_ff;
   logic               s1_ped_en_ff;

   // Stage 2: multiply.
   logic signed [16:0] s1_diff;
   logic signed [33:0] s1_prod;
   logic               s2_valid_ff;
   logic signed [16:0] s2_shift_ff;
   logic signed [15:0] s2_a_ff, s2_p_ff;

   // Stage 3: output register.
   logic               out_valid_ff;
   logic signed [16:0] out_sample_ff, out_sample_in;

   // The whole pipeline moves together unless a result waits at the output.
   assign adv          = !out_valid_ff || rsp_ready;
   assign q_pop        = adv && q_valid;
   assign pop_tick     = q_pop && (q_entry.op == OP_TICK);
   assign tab_addr_nxt = q_entry.tab_addr + TAB_AW'(1);

   always_ff @(posedge clock) begin
      if (q_pop && (q_entry.op == OP_WR_SAMPLE)) begin
         sample_mem[q_entry.tab_addr] <= q_entry.data;
      end
      if (q_pop && (q_entry.op == OP_WR_PEDAL)) begin
         pedal_mem[q_entry.ped_addr] <= q_entry.data;
      end
      if (adv) begin
         s1_a_ff <= sample_mem[q_entry.tab_addr];
         s1_b_ff <= sample_mem[tab_addr_nxt];
         s1_p_ff <= pedal_mem[q_entry.ped_addr];
      end
   end

   always_comb begin
      s1_diff       = 17'(s1_b_ff) - 17'(s1_a_ff);
      s1_prod       = $signed({1'b0, s1_frac_ff}) * s1_diff;
      // Bits 32 and up of the product are sign; dropping 16 low bits floors.
      out_sample_in = 17'(s2_a_ff) + s2_shift_ff + 17'(s2_p_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_frac_ff    <= q_entry.frac;
         s1_ped_en_ff  <= q_entry.ped_en;
         s2_shift_ff   <= s1_prod[32:16];
         s2_a_ff       <= s1_a_ff;
         s2_p_ff       <= s1_ped_en_ff ? s1_p_ff : 16'sd0;
         out_sample_ff <= out_sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= pop_tick;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_sample = out_sample_ff;

endmodule

// ===== verif/wave_check_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the looped wavetable player. It predicts the sample of each
// tick from the accepted commands and checks the results in order.
// Depends on lwp_pkg for the command codes, register indexes and table depths.
package wave_check_pkg;
   import lwp_pkg::*;

   class wave_scoreboard;
      logic signed [15:0] sample_mem [TABLE_DEPTH];
      bit                 sample_seen [TABLE_DEPTH];
      logic signed [15:0] pedal_mem [PEDAL_DEPTH];
      bit                 pedal_seen [PEDAL_DEPTH];

      bit [31:0] phase;
      bit        pedal_on;
      bit [15:0] pedal_pos;

      bit [23:0] phase_inc;
      bit [15:0] start_pos;
      bit [15:0] loop_lo;
      bit [15:0] loop_hi;
      bit [16:0] pedal_len;

      logic signed [16:0] expected_samples [$];
      int errors;
      int samples_seen;

      function new();
         phase        = '0;
         pedal_on     = 1'b0;
         pedal_pos    = '0;
         phase_inc    = PHASE_STEP_RST;
         start_pos    = START_POS_RST;
         loop_lo      = LOOP_START_RST;
         loop_hi      = LOOP_END_RST;
         pedal_len    = PEDAL_LENGTH_RST;
         errors       = 0;
         samples_seen = 0;
      endfunction

      function void set_reg(logic [2:0] index, logic [23:0] value);
         case (index)
            CSR_PHASE_STEP:   phase_inc = value;
            CSR_START_POS:    start_pos = value[15:0];
            CSR_LOOP_START:   loop_lo   = value[15:0];
            CSR_LOOP_END:     loop_hi   = value[15:0];
            CSR_PEDAL_LENGTH: pedal_len = value[16:0];
            default: ;
         endcase
      endfunction

      // Interpolated table word plus pedal word, then the phase advance.
      function logic signed [16:0] render_tick();
         bit [TAB_AW-1:0] pos;
         bit [TAB_AW-1:0] pos_next;
         longint          a;
         longint          b;
         longint          frac;
         longint          acc;
         int              eff_len;
         pos      = phase[31:16];
         pos_next = pos + 1'b1;
         a        = sample_mem[pos];
         b        = sample_mem[pos_next];
         frac     = phase[15:0];
         // Arithmetic shift of a signed product floors toward minus infinity.
         acc      = a + ((frac * (b - a)) >>> 16);
         if (pedal_on) begin
            if (pedal_len == 0) eff_len = 1;
            else if (pedal_len > PEDAL_DEPTH) eff_len = PEDAL_DEPTH;
            else eff_len = pedal_len;
            acc += pedal_mem[pedal_pos];
            if (int'(pedal_pos) + 1 >= eff_len) begin
               pedal_on  = 1'b0;
               pedal_pos = '0;
            end else begin
               pedal_pos = pedal_pos + 1'b1;
            end
         end
         phase = phase + phase_inc;
         if (phase > {loop_hi, 16'h0000})
            phase = {loop_lo, 16'h0000} + (phase - {loop_hi, 16'h0000});
         return acc[16:0];
      endfunction

      function void note_input(logic [2:0] cmd, logic [15:0] addr, logic [15:0] data);
         case (cmd)
            CMD_TICK:  expected_samples.push_back(render_tick());
            CMD_NOTE:  phase = {start_pos, 16'h0000};
            CMD_PEDAL: begin
               pedal_on  = 1'b1;
               pedal_pos = '0;
            end
            CMD_WR_SAMPLE: begin
               sample_mem[addr]  = data;
               sample_seen[addr] = 1'b1;
            end
            CMD_WR_PEDAL: begin
               pedal_mem[addr]  = data;
               pedal_seen[addr] = 1'b1;
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [23:0] tdata);
         logic signed [16:0] want;
         samples_seen++;
         if (expected_samples.size() == 0) begin
            errors++;
            if (errors <= 100)
               $error("sample_out: expected none, actual %0d", $signed(tdata[16:0]));
            return;
         end
         want = expected_samples.pop_front();
         if (tdata[16:0] !== want) begin
            errors++;
            if (errors <= 100)
               $error("sample_out: expected %0d, actual %0d", want, $signed(tdata[16:0]));
         end
         if (tdata[23:17] !== 7'd0) begin
            errors++;
            if (errors <= 100)
               $error("pad: expected 0, actual %0h", tdata[23:17]);
         end
      endfunction
   endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the testbench for looped_wavetable_player_unit: clock, reset, command
// and result drivers, register loading, directed and random stimulus.
// Depends on lwp_pkg, wave_check_pkg and the RTL of the block.
module tb_top;
   import lwp_pkg::*;
   import wave_check_pkg::*;

   localparam int CYCLE_LIMIT     = 300000;
   // Room to drain the pipeline and a four-entry queue of table writes that
   // produce no result, with some margin.
   localparam int DRAIN_CYCLES    = 16;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 230;
   // The receiver holds off once, after this many results, for this long.
   localparam int HOLD_AFTER      = 150;
   localparam int HOLD_CYCLES     = 300;

   // Command codes the block ignores.
   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;      // [15:0] address, [31:16] data (signed)
   logic [2:0]  req_tuser  = CMD_TICK; // [2:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;            // [16:0] sample_out (signed), rest zero
   logic        csr_wen    = 1'b0;
   logic [2:0]  csr_index  = CSR_PHASE_STEP;
   logic [23:0] csr_wdata  = '0;

   wave_scoreboard sb;

   // Sender pacing: a burst runs for burst_left more transfers, then a gap
   // follows unless the current phase runs without gaps.
   int burst_left  = 0;
   bit gapless     = 1'b0;
   int cycle_count = 0;
   // Every command transfer, table writes added by play_tick included.
   int items_sent  = 0;

   looped_wavetable_player_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Offers one command and waits for its transfer. The prediction is updated
   // at acceptance, so the next command is chosen against the current state.
   // The valid is only lowered when a gap follows, which keeps a single
   // nonblocking update per time step on req_tvalid.
   task automatic send_item(input logic [2:0] cmd, input logic [15:0] addr,
                            input logic [15:0] data);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {data, addr};
      do begin
         @(posedge clock);
      end while (!req_tready);
      sb.note_input(cmd, addr, data);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = gapless ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // A tick may only read table words that were written. Any word the next
   // tick needs and that is still blank gets a random value first.
   task automatic play_tick();
      logic [15:0] pos;
      logic [15:0] pos_next;
      pos      = sb.phase[31:16];
      pos_next = pos + 16'd1;
      if (!sb.sample_seen[pos]) send_item(CMD_WR_SAMPLE, pos, $urandom);
      if (!sb.sample_seen[pos_next]) send_item(CMD_WR_SAMPLE, pos_next, $urandom);
      if (sb.pedal_on && !sb.pedal_seen[sb.pedal_pos])
         send_item(CMD_WR_PEDAL, sb.pedal_pos, $urandom);
      send_item(CMD_TICK, $urandom, $urandom);
   endtask

   // Stops offering, waits for every expected sample, then lets the queued
   // table writes that carry no result run through the pipeline.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [23:0] value);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_reg(index, value);
   endtask

   // Writes all five registers back to back; only called while idle.
   task automatic load_settings(input logic [23:0] inc, input logic [15:0] start,
                                input logic [15:0] lo, input logic [15:0] hi,
                                input logic [16:0] plen);
      write_reg(CSR_PHASE_STEP, inc);
      write_reg(CSR_START_POS, {8'd0, start});
      write_reg(CSR_LOOP_START, {8'd0, lo});
      write_reg(CSR_LOOP_END, {8'd0, hi});
      write_reg(CSR_PEDAL_LENGTH, {7'd0, plen});
      csr_wen <= 1'b0;
   endtask

   // One random phase: fresh settings, mostly a note followed by ticks with
   // table writes near the playing position, plus pedal starts and noise.
   // The phase ends once it has sent the given number of transfers.
   task automatic run_random_phase(input int items);
      logic [23:0] inc;
      logic [15:0] start;
      logic [15:0] lo;
      logic [15:0] hi;
      logic [16:0] plen;
      logic [15:0] pos;
      logic [15:0] offset;
      int          first;
      int          r;
      case ($urandom_range(0, 5))
         0:       inc = 24'hFFFFFF;
         1:       inc = '0;
         2:       inc = $urandom;
         default: inc = $urandom_range(0, 24'h03FFFF);
      endcase
      case ($urandom_range(0, 3))
         0:       start = 16'h0000;
         1:       start = 16'hFFFF;
         default: start = $urandom;
      endcase
      // Often a short loop from the start position, so ticks revisit words.
      case ($urandom_range(0, 4))
         1: begin
            // Loop start above loop end: the wrap moves the phase forward.
            hi = $urandom_range(0, 65533);
            lo = $urandom_range(hi + 1, 65535);
         end
         2: begin
            lo = 16'h0000;
            hi = 16'd65534;
         end
         3: begin
            lo = $urandom;
            hi = $urandom_range(0, 65534);
         end
         default: begin
            lo = start;
            hi = (start > 16'd65454) ? 16'd65534 : start + $urandom_range(0, 80);
         end
      endcase
      case ($urandom_range(0, 5))
         0:       plen = '0;
         1:       plen = 17'd1;
         2:       plen = 17'd65536;
         3:       plen = 17'h1FFFF;
         default: plen = $urandom_range(2, 12);
      endcase
      gapless = ($urandom_range(0, 3) == 0);
      load_settings(inc, start, lo, hi, plen);
      first = items_sent;
      if ($urandom_range(0, 4) != 0) send_item(CMD_NOTE, $urandom, $urandom);
      while (items_sent - first < items) begin
         r      = $urandom_range(0, 99);
         pos    = sb.phase[31:16];
         offset = $urandom_range(0, 8);
         if (r < 55) begin
            play_tick();
         end else if (r < 59) begin
            send_item(CMD_NOTE, $urandom, $urandom);
         end else if (r < 65) begin
            send_item(CMD_PEDAL, $urandom, $urandom);
         end else if (r < 79) begin
            send_item(CMD_WR_SAMPLE, pos + offset, $urandom);
         end else if (r < 85) begin
            send_item(CMD_WR_SAMPLE, $urandom, $urandom);
         end else if (r < 90) begin
            send_item(CMD_WR_PEDAL, sb.pedal_pos + offset, $urandom);
         end else if (r < 94) begin
            send_item(CMD_WR_PEDAL, $urandom, $urandom);
         end else begin
            // Unused commands are ignored by the block.
            send_item($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST), $urandom, $urandom);
         end
      end
      wait_idle();
   endtask

   // Receiver: checks every result transfer and paces rsp_tready with a
   // pattern of its own (always ready, coin flip, mostly stalled). Once, after
   // enough results, it holds off long enough for the queue to fill and the
   // block to drop req_tready while the sender keeps offering.
   initial begin
      int mode;
      int mode_left;
      int hold_left;
      bit held;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      held      = 1'b0;
      do begin
         @(posedge clock);
      end while (reset);
      forever begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (!held && sb.samples_seen >= HOLD_AFTER) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(5, 60);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= $urandom_range(0, 1);
               default: rsp_tready <= ($urandom_range(0, 4) == 0);
            endcase
         end
         @(posedge clock);
      end
   end

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: unit step from phase zero, pedal of one word.
      // Extreme words at both ends of the table and both data extremes.
      send_item(CMD_WR_SAMPLE, 16'h0000, 16'h7FFF);
      send_item(CMD_WR_SAMPLE, 16'h0001, 16'h8000);
      send_item(CMD_WR_SAMPLE, 16'h0002, 16'h7FFF);
      play_tick();
      play_tick();
      for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
         send_item(3'(c), 16'hFFFF, 16'hFFFF);
      send_item(CMD_WR_PEDAL, 16'h0000, 16'h7FFF);
      // Starting the pedal while it plays restarts it.
      send_item(CMD_PEDAL, 16'h0000, 16'h0000);
      send_item(CMD_PEDAL, 16'hFFFF, 16'hFFFF);
      // Largest positive sum: top table word plus top pedal word.
      play_tick();
      play_tick();
      send_item(CMD_WR_SAMPLE, 16'hFFFF, 16'h8000);
      send_item(CMD_WR_PEDAL, 16'hFFFF, 16'h8000);
      send_item(CMD_WR_PEDAL, 16'h0000, 16'h8000);
      wait_idle();

      // Half step from the last table word, so the next word comes from the
      // start of the table; loop end one word below its top so the first step wraps.
      // A pedal length of zero plays one word. The first tick gives the most
      // negative sum, the second interpolates halfway across full scale.
      load_settings(24'h008000, 16'hFFFF, 16'h0000, 16'd65534, 17'd0);
      send_item(CMD_NOTE, 16'h0000, 16'h0000);
      send_item(CMD_PEDAL, 16'h0000, 16'h0000);
      play_tick();
      play_tick();
      wait_idle();

      // Largest step, loop start above loop end, pedal length beyond the
      // pedal table.
      load_settings(24'hFFFFFF, 16'h0000, 16'd60000, 16'd1000, 17'h1FFFF);
      send_item(CMD_NOTE, 16'h0000, 16'h0000);
      send_item(CMD_PEDAL, 16'h0000, 16'h0000);
      repeat (4) play_tick();
      wait_idle();

      for (int i = 0; i < RANDOM_PHASES; i++) run_random_phase(ITEMS_PER_PHASE);

      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lwp_pkg.sv
rtl/lwp_front.sv
rtl/lwp_queue.sv
rtl/lwp_back.sv
rtl/looped_wavetable_player_unit.sv
verif/wave_check_pkg.sv
verif/tb_top.sv
